>>> hw/rtl/nlp_pkg.sv
// Package for the numeric literal parser: character codes, the per-character
// classification record and the decimal saturation limit.
// No dependencies.
package nlp_pkg;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_ONE        = 8'h31;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
  localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_B    = 8'h42;
  localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
  localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X    = 8'h58;

  // Largest decimal value that can take another digit without overflow.
  localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

  // One character after classification. A character that is not kept is an
  // underscore that closes the literal.
  typedef struct packed {
    logic       kept;
    logic       last;
    logic       is_zero;
    logic       is_x;
    logic       is_suffix;
    logic       bin_ok;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       dec_ok;
  } char_info_t;

endpackage

>>> hw/rtl/nlp_front.sv
// Front end of the numeric literal parser: accepts characters, classifies
// them and drops underscores that do not close a literal.
// Depends on nlp_pkg.
module nlp_front (
  input  logic                [7:0] char_code,
  input  logic                      is_last,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      q_ready,
  output logic                      q_push,
  output nlp_pkg::char_info_t       q_data
);
  import nlp_pkg::*;

  logic kept;

  assign kept     = (char_code != CHAR_UNDERSCORE);
  assign in_ready = q_ready;
  // An underscore in the middle of a literal changes nothing downstream.
  assign q_push   = in_valid && q_ready && (kept || is_last);

  always_comb begin
    q_data           = '0;
    q_data.kept      = kept;
    q_data.last      = is_last;
    q_data.is_zero   = (char_code == CHAR_ZERO);
    q_data.is_x      = (char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X);
    q_data.is_suffix = (char_code == CHAR_LOWER_B) || (char_code == CHAR_UPPER_B);
    q_data.bin_ok    = (char_code == CHAR_ZERO) || (char_code == CHAR_ONE);
    q_data.dec_ok    = char_code inside {[CHAR_ZERO:CHAR_NINE]};
    if (char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
      q_data.hex_ok  = 1'b1;
      q_data.hex_val = 4'(char_code - CHAR_ZERO);
    end else if (char_code inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
      q_data.hex_ok  = 1'b1;
      q_data.hex_val = 4'(char_code - CHAR_LOWER_A + 8'd10);
    end else if (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
      q_data.hex_ok  = 1'b1;
      q_data.hex_val = 4'(char_code - CHAR_UPPER_A + 8'd10);
    end else begin
      q_data.hex_ok  = 1'b0;
      q_data.hex_val = 4'd0;
    end
  end

endmodule

>>> hw/rtl/nlp_queue.sv
// Two-entry queue of classified characters between front and back end.
// A push and a pop may happen in the same cycle. Depends on nlp_pkg.
module nlp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nlp_pkg::char_info_t push_data,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output nlp_pkg::char_info_t pop_data
);
  import nlp_pkg::*;

  char_info_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hw/rtl/nlp_back.sv
// Back end of the numeric literal parser: runs the binary, hex and decimal
// accumulators side by side and registers the result of each literal.
// Depends on nlp_pkg.
module nlp_back #(
  parameter int MAX_HEX_DIGITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  nlp_pkg::char_info_t q_data,
  output logic                q_pop,
  output logic         [63:0] value_low,
  output logic         [15:0] value_high,
  output logic                ok,
  output logic                out_valid,
  input  logic                out_ready
);
  import nlp_pkg::*;

  localparam int CW = $clog2(MAX_HEX_DIGITS + 2);
  localparam logic [CW-1:0] HEX_MAX = CW'(MAX_HEX_DIGITS);

  logic [1:0]    kept_count, kept_count_next;
  logic          first_is_zero, first_is_zero_next;
  logic          hex_mode, hex_mode_next;
  logic          held_bin_ok, held_bin_ok_next;
  logic          held_bit, held_bit_next;
  logic          held_suffix, held_suffix_next;
  logic [63:0]   bin_acc, bin_acc_next;
  logic          bin_good, bin_good_next;
  logic [63:0]   hex_low_acc, hex_low_acc_next;
  logic [15:0]   hex_high_acc, hex_high_acc_next;
  logic [CW-1:0] hex_cnt, hex_cnt_next;
  logic          hex_good, hex_good_next;
  logic [63:0]   dec_acc, dec_acc_next;
  logic          dec_good, dec_good_next;
  logic [63:0]   res_low;
  logic [15:0]   res_high;
  logic          res_ok;

  // A closing character needs the output register free.
  assign q_pop = q_valid && (!q_data.last || !out_valid || out_ready);

  always_comb begin
    kept_count_next    = kept_count;
    first_is_zero_next = first_is_zero;
    hex_mode_next      = hex_mode;
    held_bin_ok_next   = held_bin_ok;
    held_bit_next      = held_bit;
    held_suffix_next   = held_suffix;
    bin_acc_next       = bin_acc;
    bin_good_next      = bin_good;
    hex_low_acc_next   = hex_low_acc;
    hex_high_acc_next  = hex_high_acc;
    hex_cnt_next       = hex_cnt;
    hex_good_next      = hex_good;
    dec_acc_next       = dec_acc;
    dec_good_next      = dec_good;
    if (q_data.kept) begin
      // The held character is now known not to be the suffix.
      if (kept_count != 2'd0) begin
        if (held_bin_ok) begin
          bin_acc_next = {bin_acc[62:0], held_bit};
        end else begin
          bin_good_next = 1'b0;
        end
      end
      if (kept_count == 2'd0) begin
        first_is_zero_next = q_data.is_zero;
      end else if (kept_count == 2'd1) begin
        hex_mode_next = first_is_zero && q_data.is_x;
      end else if (hex_mode) begin
        if (q_data.hex_ok) begin
          hex_low_acc_next  = {hex_low_acc[59:0], q_data.hex_val};
          hex_high_acc_next = {hex_high_acc[11:0], hex_low_acc[63:60]};
        end else begin
          hex_good_next = 1'b0;
        end
        if (hex_cnt <= HEX_MAX) begin
          hex_cnt_next = hex_cnt + CW'(1);
        end
      end
      if (q_data.dec_ok) begin
        if (dec_acc > DEC_LIMIT || (dec_acc == DEC_LIMIT && q_data.hex_val > 4'd5)) begin
          dec_acc_next = '1;
        end else begin
          dec_acc_next = {dec_acc[60:0], 3'b000} + {dec_acc[62:0], 1'b0}
                       + {60'd0, q_data.hex_val};
        end
      end else begin
        dec_good_next = 1'b0;
      end
      held_bin_ok_next = q_data.bin_ok;
      held_bit_next    = q_data.is_zero ? 1'b0 : 1'b1;
      held_suffix_next = q_data.is_suffix;
      if (kept_count != 2'd2) begin
        kept_count_next = kept_count + 2'd1;
      end
    end
  end

  always_comb begin
    res_low  = 64'd0;
    res_high = 16'd0;
    res_ok   = 1'b0;
    if (kept_count_next == 2'd0) begin
      res_ok = 1'b0;
    end else if (held_suffix_next && !hex_mode_next) begin
      res_ok  = (kept_count_next == 2'd2) && bin_good_next;
      res_low = bin_acc_next;
    end else if (hex_mode_next) begin
      res_ok   = hex_good_next && (hex_cnt_next != '0) && (hex_cnt_next <= HEX_MAX);
      res_low  = hex_low_acc_next;
      res_high = hex_high_acc_next;
    end else begin
      res_ok  = dec_good_next;
      res_low = dec_acc_next;
    end
    if (!res_ok) begin
      res_low  = 64'd0;
      res_high = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (q_pop && q_data.last)) begin
      kept_count    <= 2'd0;
      first_is_zero <= 1'b0;
      hex_mode      <= 1'b0;
      held_bin_ok   <= 1'b0;
      held_bit      <= 1'b0;
      held_suffix   <= 1'b0;
      bin_acc       <= 64'd0;
      bin_good      <= 1'b1;
      hex_low_acc   <= 64'd0;
      hex_high_acc  <= 16'd0;
      hex_cnt       <= '0;
      hex_good      <= 1'b1;
      dec_acc       <= 64'd0;
      dec_good      <= 1'b1;
    end else if (q_pop) begin
      kept_count    <= kept_count_next;
      first_is_zero <= first_is_zero_next;
      hex_mode      <= hex_mode_next;
      held_bin_ok   <= held_bin_ok_next;
      held_bit      <= held_bit_next;
      held_suffix   <= held_suffix_next;
      bin_acc       <= bin_acc_next;
      bin_good      <= bin_good_next;
      hex_low_acc   <= hex_low_acc_next;
      hex_high_acc  <= hex_high_acc_next;
      hex_cnt       <= hex_cnt_next;
      hex_good      <= hex_good_next;
      dec_acc       <= dec_acc_next;
      dec_good      <= dec_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_data.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      value_low  <= res_low;
      value_high <= res_high;
      ok         <= res_ok;
    end
  end

endmodule

>>> hw/rtl/numeric_literal_parser_top.sv
// Numeric literal parser: one character per transfer, one result per literal.
// A closing character passes through the queue, then its result is registered.
// Throughput: one character per cycle; a closing one stalls on a pending result.
// A two-entry queue lets the input keep going while a result waits to be taken.
// Reset (rst, synchronous) empties the queue and output and clears the literal.
module numeric_literal_parser_top #(
  parameter int MAX_HEX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic  [7:0] char_code,
  input  logic        is_last,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [63:0] value_low,
  output logic [15:0] value_high,
  output logic        ok,
  output logic        out_valid,
  input  logic        out_ready
);
  import nlp_pkg::*;

  char_info_t push_data;
  char_info_t pop_data;
  logic       push;
  logic       push_ready;
  logic       pop;
  logic       pop_valid;

  nlp_front u_front (
    .char_code (char_code),
    .is_last   (is_last),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_ready   (push_ready),
    .q_push    (push),
    .q_data    (push_data)
  );

  nlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  nlp_back #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_pop      (pop),
    .value_low  (value_low),
    .value_high (value_high),
    .ok         (ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

>>> hw/rtl/nlp_checker.sv
// Port-level checks for the numeric literal parser, bound to the top level.
// Depends only on the ports of numeric_literal_parser_top.
module nlp_checker (
  input logic        clk,
  input logic        rst,
  input logic [63:0] value_low,
  input logic [15:0] value_high,
  input logic        ok,
  input logic        out_valid,
  input logic        out_ready
);

  // A malformed literal reports a zero value.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> value_low == 64'd0 && value_high == 16'd0)
    else $error("malformed literal with nonzero value");

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_low)
      && $stable(value_high) && $stable(ok))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // No result can appear in the cycle right after reset.
  a_no_early_result: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result directly after reset");

endmodule

bind numeric_literal_parser_top nlp_checker u_nlp_checker (
  .clk        (clk),
  .rst        (rst),
  .value_low  (value_low),
  .value_high (value_high),
  .ok         (ok),
  .out_valid  (out_valid),
  .out_ready  (out_ready)
);
